@@ hdl/calendar_date_unit_assert.svh @@
// Assertion macros for the calendar date unit RTL.
// Depends on a clock named clk and an active-high reset named rst in the including module.
`ifndef CALENDAR_DATE_UNIT_ASSERT_SVH
`define CALENDAR_DATE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define CDU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("calendar_date_unit: assertion failed");
`define CDU_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("calendar_date_unit: reset assertion failed");
`else
`define CDU_ASSERT(lbl, prop)
`define CDU_ASSERT_RST(lbl, prop)
`endif

`endif

@@ hdl/cdu_pkg.sv @@
// Shared constants, types and calendar tables for the calendar date unit.
// No dependencies; used by cdu_date_path and calendar_date_unit.
package cdu_pkg;

  localparam int MAX_YEAR      = 9999;
  localparam int YEAR_OFFSET   = 400;
  localparam int DAYS_PER_YEAR = 365;
  localparam int RECIP_25      = 5243;
  localparam int RECIP_SHIFT   = 17;
  localparam int Q25_W         = 10;
  localparam int DAY_NUM_W     = 22;

  localparam logic [1:0] ORD_EQUAL   = 2'b00;
  localparam logic [1:0] ORD_LATER   = 2'b01;
  localparam logic [1:0] ORD_EARLIER = 2'b11;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_en_t;

  typedef struct packed {
    logic                 valid;
    logic                 leap;
    logic [DAY_NUM_W-1:0] day_num;
    logic [4:0]           next_day;
    logic [3:0]           next_month;
    logic [13:0]          next_year;
  } date_res_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    n = 5'd0;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days from 1 March to the first of the month, with January and February
  // counted at the end of the previous year.
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] n;
    n = 9'd0;
    unique case (m)
      4'd3:    n = 9'd0;
      4'd4:    n = 9'd31;
      4'd5:    n = 9'd61;
      4'd6:    n = 9'd92;
      4'd7:    n = 9'd122;
      4'd8:    n = 9'd153;
      4'd9:    n = 9'd184;
      4'd10:   n = 9'd214;
      4'd11:   n = 9'd245;
      4'd12:   n = 9'd275;
      4'd1:    n = 9'd306;
      4'd2:    n = 9'd337;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hdl/calendar_date_unit.sv @@
// Top level of the calendar date unit: stream ports, pipeline control and the final stage.
// Depends on cdu_pkg, cdu_date_path and calendar_date_unit_assert.svh.
//
// Each input transaction on the s_ channel carries two Gregorian dates; each
// produces exactly one output transaction on the m_ channel, in order. The
// result holds both validity flags, the order of the dates, the absolute
// distance in days, the leap flag of the first year and the date after the
// first date.
// The unit is a four-stage pipeline: year terms, leap test and century terms,
// day numbers with validity and successor, then the distance and output
// register. One transaction can be accepted in every cycle while the receiver
// takes results or the pipeline still has an empty stage.
// Each stage has its own valid bit and moves forward when the next stage is
// empty or moving, so a stalled receiver holds the output register while
// earlier stages keep filling; s_tready falls only when all four are full.
// Reset empties the pipeline; nothing is presented until new input arrives.
module calendar_date_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // day_a[4:0], month_a[8:5], year_a[22:9], day_b[27:23], month_b[31:28],
  // year_b[45:32], zero padding [47:46]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // valid_a[0], valid_b[1], order[3:2], days_between[25:4], leap_a[26],
  // next_day[31:27], next_month[35:32], next_year[49:36], zero padding [55:50]
  output logic [55:0] m_tdata
);

  `include "calendar_date_unit_assert.svh"

  logic [4:0]  day_a, day_b;
  logic [3:0]  month_a, month_b;
  logic [13:0] year_a, year_b;

  assign day_a   = s_tdata[4:0];
  assign month_a = s_tdata[8:5];
  assign year_a  = s_tdata[22:9];
  assign day_b   = s_tdata[27:23];
  assign month_b = s_tdata[31:28];
  assign year_b  = s_tdata[45:32];

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  cdu_pkg::stage_en_t en;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign en.ld1   = rdy1;
  assign en.ld2   = rdy2;
  assign en.ld3   = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  cdu_pkg::date_res_t res_a, res_b;

  cdu_date_path u_path_a (
    .clk   (clk),
    .en    (en),
    .day   (day_a),
    .month (month_a),
    .year  (year_a),
    .res   (res_a)
  );

  cdu_date_path u_path_b (
    .clk   (clk),
    .en    (en),
    .day   (day_b),
    .month (month_b),
    .year  (year_b),
    .res   (res_b)
  );

  // The order compares the raw fields, year first, then month, then day.
  logic [22:0] key_a, key_b;
  logic [1:0]  ord_next;
  logic [1:0]  ord1, ord2, ord3, ord4;

  assign key_a    = {year_a, month_a, day_a};
  assign key_b    = {year_b, month_b, day_b};
  assign ord_next = (key_a > key_b) ? cdu_pkg::ORD_LATER :
                    (key_a < key_b) ? cdu_pkg::ORD_EARLIER : cdu_pkg::ORD_EQUAL;

  always_ff @(posedge clk) begin
    if (rdy1) ord1 <= ord_next;
    if (rdy2) ord2 <= ord1;
    if (rdy3) ord3 <= ord2;
  end

  logic [cdu_pkg::DAY_NUM_W-1:0] dist_next;
  logic [cdu_pkg::DAY_NUM_W-1:0] dist4;
  logic                          va4, vb4, leap4;
  logic [4:0]                    nd4;
  logic [3:0]                    nm4;
  logic [13:0]                   ny4;

  always_comb begin
    dist_next = '0;
    if (res_a.valid && res_b.valid) begin
      dist_next = (res_a.day_num >= res_b.day_num) ? res_a.day_num - res_b.day_num :
                                                    res_b.day_num - res_a.day_num;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      ord4  <= ord3;
      dist4 <= dist_next;
      va4   <= res_a.valid;
      vb4   <= res_b.valid;
      leap4 <= res_a.leap;
      nd4   <= res_a.next_day;
      nm4   <= res_a.next_month;
      ny4   <= res_a.next_year;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {6'd0, ny4, nm4, nd4, leap4, dist4, ord4, vb4, va4};

  `CDU_ASSERT_RST(a_reset_empties, rst |=> !m_tvalid)
  `CDU_ASSERT(a_dist_needs_both_valid, (v4 && (dist4 != '0)) |-> (va4 && vb4))
  `CDU_ASSERT(a_equal_dates_no_dist, (v4 && (ord4 == cdu_pkg::ORD_EQUAL)) |-> (dist4 == '0))
  `CDU_ASSERT(a_next_zero_if_invalid, (v4 && !va4) |-> ((nd4 == 5'd0) && (nm4 == 4'd0)))
  `CDU_ASSERT(a_full_pipe_blocks_input, (v1 && v2 && v3 && v4 && !m_tready) |-> !s_tready)

endmodule

@@ hdl/cdu_date_path.sv @@
// Three-stage datapath for one date: leap test, day number, validity and successor date.
// Depends on cdu_pkg; stage loads come from the pipeline control in calendar_date_unit.
module cdu_date_path (
  input  logic               clk,
  input  cdu_pkg::stage_en_t en,
  input  logic [4:0]         day,
  input  logic [3:0]         month,
  input  logic [13:0]        year,
  output cdu_pkg::date_res_t res
);

  // Stage 1: March-based year and year divided by 25.
  logic                            early;
  logic [14:0]                     yy_next;
  logic [26:0]                     q_prod;
  logic [4:0]                      d1;
  logic [3:0]                      m1;
  logic [13:0]                     y1;
  logic [14:0]                     yy1;
  logic [cdu_pkg::Q25_W-1:0]       q1;

  assign early   = (month <= 4'd2);
  assign yy_next = 15'(year) + 15'(cdu_pkg::YEAR_OFFSET) - 15'(early);
  assign q_prod  = 27'(year) * 27'(cdu_pkg::RECIP_25);

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      d1  <= day;
      m1  <= month;
      y1  <= year;
      yy1 <= yy_next;
      q1  <= q_prod[cdu_pkg::RECIP_SHIFT +: cdu_pkg::Q25_W];
    end
  end

  // Stage 2: leap flag and the century terms of the day number.
  logic [13:0] r25;
  logic        leap_next;
  logic [25:0] c100_prod;
  logic [25:0] c400_prod;
  logic [23:0] y365_next;
  logic [4:0]  d2;
  logic [3:0]  m2;
  logic [13:0] y2;
  logic        leap2;
  logic [23:0] y365_2;
  logic [12:0] q4_2;
  logic [8:0]  c100_2;
  logic [8:0]  c400_2;

  assign r25       = y1 - 14'(14'(q1) * 14'd25);
  assign leap_next = (y1[1:0] == 2'd0) && ((r25 != 14'd0) || (y1[3:0] == 4'd0));
  assign c100_prod = 26'(yy1[14:2]) * 26'(cdu_pkg::RECIP_25);
  assign c400_prod = 26'(yy1[14:4]) * 26'(cdu_pkg::RECIP_25);
  assign y365_next = 24'(yy1) * 24'(cdu_pkg::DAYS_PER_YEAR);

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      d2     <= d1;
      m2     <= m1;
      y2     <= y1;
      leap2  <= leap_next;
      y365_2 <= y365_next;
      q4_2   <= yy1[14:2];
      c100_2 <= c100_prod[25:17];
      c400_2 <= c400_prod[25:17];
    end
  end

  // Stage 3: validity, day number and the following date.
  logic [4:0]  dim;
  logic        ok;
  logic [23:0] dn_sum;
  logic [5:0]  nd_inc;
  logic        day_wrap;
  logic [4:0]  nm_inc;
  logic        year_wrap;
  logic [4:0]  nd;
  logic [3:0]  nm;
  logic [13:0] ny;

  assign dim = cdu_pkg::month_days(m2, leap2);
  assign ok  = (int'(y2) <= cdu_pkg::MAX_YEAR) && (m2 >= 4'd1) && (m2 <= 4'd12) &&
               (d2 != 5'd0) && (d2 <= dim);
  assign dn_sum = y365_2 + 24'(q4_2) - 24'(c100_2) + 24'(c400_2) +
                  24'(cdu_pkg::month_offset(m2)) + 24'(d2);

  assign nd_inc    = 6'(d2) + 6'd1;
  assign day_wrap  = nd_inc > 6'(dim);
  assign nm_inc    = day_wrap ? 5'(m2) + 5'd1 : 5'(m2);
  assign year_wrap = nm_inc > 5'd12;
  assign nd        = day_wrap ? 5'd1 : nd_inc[4:0];
  assign nm        = year_wrap ? 4'd1 : nm_inc[3:0];
  assign ny        = year_wrap ? y2 + 14'd1 : y2;

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      res.valid      <= ok;
      res.leap       <= leap2;
      res.day_num    <= dn_sum[cdu_pkg::DAY_NUM_W-1:0];
      res.next_day   <= ok ? nd : 5'd0;
      res.next_month <= ok ? nm : 4'd0;
      res.next_year  <= ok ? ny : 14'd0;
    end
  end

endmodule

@@ test/tb_calendar_date_unit.sv @@
// Self-checking testbench for calendar_date_unit: drives date pairs on the input stream,
// predicts each result independently and checks every output transaction in order.
// Depends on cdu_pkg and calendar_date_unit.
module tb_calendar_date_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_STALL  = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int PHASE_ITEMS = 375;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } date_t;

  typedef struct packed {
    date_t a;
    date_t b;
  } date_pair_t;

  typedef struct packed {
    logic        valid_a;
    logic        valid_b;
    logic [1:0]  order;
    logic [21:0] days_between;
    logic        leap_a;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
  } date_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  date_pair_t    queued_pairs[$];
  date_outcome_t expected_outcomes[$];
  int queued_total   = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_requests = 0;
  int stalls_served  = 0;
  int stall_left     = 0;
  int quiet_cycles   = 0;

  calendar_date_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(int m, int y);
    case (m) inside
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic logic real_date(date_t d);
    return d.year <= cdu_pkg::MAX_YEAR && d.month >= 1 && d.month <= 12 &&
           d.day >= 1 && d.day <= month_length(int'(d.month), int'(d.year));
  endfunction

  // Days counted from a March-based year 400 years before year 0.
  function automatic int serial_day(date_t d);
    int yy;
    int mm;
    yy = int'(d.year) + 400;
    if (d.month <= 2) begin
      yy = yy - 1;
      mm = int'(d.month) + 9;
    end else begin
      mm = int'(d.month) - 3;
    end
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm + 2) / 5 + int'(d.day);
  endfunction

  function automatic date_outcome_t date_pair_outcome(date_pair_t p);
    date_outcome_t r;
    int na;
    int nb;
    int nd;
    int nm;
    int ny;
    r = '0;
    r.valid_a = real_date(p.a);
    r.valid_b = real_date(p.b);
    if (p.a.year != p.b.year)
      r.order = (p.a.year > p.b.year) ? cdu_pkg::ORD_LATER : cdu_pkg::ORD_EARLIER;
    else if (p.a.month != p.b.month)
      r.order = (p.a.month > p.b.month) ? cdu_pkg::ORD_LATER : cdu_pkg::ORD_EARLIER;
    else if (p.a.day != p.b.day)
      r.order = (p.a.day > p.b.day) ? cdu_pkg::ORD_LATER : cdu_pkg::ORD_EARLIER;
    else
      r.order = cdu_pkg::ORD_EQUAL;
    if (r.valid_a && r.valid_b) begin
      na = serial_day(p.a);
      nb = serial_day(p.b);
      r.days_between = 22'((na >= nb) ? na - nb : nb - na);
    end
    r.leap_a = leap_year(int'(p.a.year));
    if (r.valid_a) begin
      nd = int'(p.a.day) + 1;
      nm = int'(p.a.month);
      ny = int'(p.a.year);
      if (nd > month_length(int'(p.a.month), int'(p.a.year))) begin
        nd = 1;
        nm = nm + 1;
      end
      if (nm > 12) begin
        nm = 1;
        ny = ny + 1;
      end
      r.next_day   = 5'(nd);
      r.next_month = 4'(nm);
      r.next_year  = 14'(ny);
    end
    return r;
  endfunction

  function automatic date_pair_t pair_from_bus(logic [47:0] v);
    date_pair_t p;
    p.a.day   = v[4:0];
    p.a.month = v[8:5];
    p.a.year  = v[22:9];
    p.b.day   = v[27:23];
    p.b.month = v[31:28];
    p.b.year  = v[45:32];
    return p;
  endfunction

  function automatic logic [47:0] pair_to_bus(date_pair_t p);
    return {2'b00, p.b.year, p.b.month, p.b.day, p.a.year, p.a.month, p.a.day};
  endfunction

  function automatic date_t mk_date(int d, int m, int y);
    date_t r;
    r.day   = 5'(d);
    r.month = 4'(m);
    r.year  = 14'(y);
    return r;
  endfunction

  function automatic logic [4:0] random_day(int m, int y);
    int len;
    int r;
    len = month_length(m, y);
    r = $urandom_range(99);
    if (len == 0 || r < 8)
      return 5'($urandom_range(31));
    if (r < 30)
      return 5'(len);
    return 5'($urandom_range(len, 1));
  endfunction

  function automatic date_t random_date();
    date_t d;
    int r;
    int edges[12] = '{0, 1, 99, 100, 399, 400, 1600, 1900, 2000, 2100, 9998, 9999};
    r = $urandom_range(99);
    if (r < 80)
      d.year = 14'($urandom_range(cdu_pkg::MAX_YEAR));
    else if (r < 90)
      d.year = 14'(edges[$urandom_range(11)]);
    else
      d.year = 14'($urandom_range(16383, cdu_pkg::MAX_YEAR + 1));
    d.month = ($urandom_range(99) < 92) ? 4'($urandom_range(12, 1)) : 4'($urandom_range(15));
    d.day = random_day(int'(d.month), int'(d.year));
    return d;
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t p;
    int r;
    p.a = random_date();
    r = $urandom_range(99);
    if (r < 12) begin
      p.b = p.a;
    end else if (r < 45) begin
      p.b = p.a;
      if ($urandom_range(1) == 1) begin
        if ($urandom_range(1) == 1 && p.b.year < 16383)
          p.b.year = p.b.year + 14'd1;
        else if (p.b.year > 0)
          p.b.year = p.b.year - 14'd1;
        p.b.month = 4'($urandom_range(12, 1));
      end
      p.b.day = random_day(int'(p.b.month), int'(p.b.year));
    end else begin
      p.b = random_date();
    end
    return p;
  endfunction

  task automatic queue_pair(date_t a, date_t b);
    date_pair_t p;
    p.a = a;
    p.b = b;
    queued_pairs.push_back(p);
    queued_total++;
  endtask

  task automatic wait_all_results();
    wait (results_seen >= queued_total);
    @(negedge clk);
  endtask

  task automatic run_random_phase(int s_idle, int r_idle, bit long_stall);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (PHASE_ITEMS) begin
      queued_pairs.push_back(random_pair());
      queued_total++;
    end
    if (long_stall)
      stall_requests++;
    wait_all_results();
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : driver
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready)
        expected_outcomes.push_back(date_pair_outcome(pair_from_bus(s_tdata)));
      if (!s_tvalid || s_tready) begin
        if (queued_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pair_to_bus(queued_pairs.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    date_outcome_t want;
    date_outcome_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = m_tdata[49:0];
        got.valid_a      = m_tdata[0];
        got.valid_b      = m_tdata[1];
        got.order        = m_tdata[3:2];
        got.days_between = m_tdata[25:4];
        got.leap_a       = m_tdata[26];
        got.next_day     = m_tdata[31:27];
        got.next_month   = m_tdata[35:32];
        got.next_year    = m_tdata[49:36];
        if (expected_outcomes.size() == 0) begin
          $error("Output transaction arrived with no result outstanding");
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("valid_a", want.valid_a, got.valid_a);
          check_field("valid_b", want.valid_b, got.valid_b);
          check_field("order", want.order, got.order);
          check_field("days_between", want.days_between, got.days_between);
          check_field("leap_a", want.leap_a, got.leap_a);
          check_field("next_day", want.next_day, got.next_day);
          check_field("next_month", want.next_month, got.next_month);
          check_field("next_year", want.next_year, got.next_year);
        end
      end
      if (stalls_served != stall_requests) begin
        stalls_served++;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL calendar_date_unit");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 48;
    queue_pair(mk_date(31, 12, 9999), mk_date(1, 1, 0));
    queue_pair(mk_date(1, 1, 0), mk_date(31, 12, 9999));
    queue_pair(mk_date(28, 2, 1900), mk_date(1, 3, 1900));
    queue_pair(mk_date(29, 2, 1900), mk_date(28, 2, 1900));
    queue_pair(mk_date(29, 2, 2000), mk_date(1, 3, 2000));
    queue_pair(mk_date(28, 2, 2024), mk_date(29, 2, 2024));
    queue_pair(mk_date(29, 2, 2023), mk_date(1, 1, 2023));
    queue_pair(mk_date(29, 2, 0), mk_date(1, 3, 0));
    queue_pair(mk_date(0, 5, 2020), mk_date(1, 5, 2020));
    queue_pair(mk_date(15, 0, 2020), mk_date(15, 13, 2020));
    queue_pair(mk_date(31, 4, 2021), mk_date(30, 4, 2021));
    queue_pair(mk_date(30, 4, 2021), mk_date(30, 4, 2021));
    queue_pair(mk_date(31, 12, 2023), mk_date(1, 1, 2024));
    queue_pair(mk_date(1, 1, 10000), mk_date(1, 1, 9999));
    queue_pair(mk_date(31, 15, 16383), mk_date(31, 15, 16383));
    queue_pair(mk_date(0, 0, 0), mk_date(0, 0, 0));
    queue_pair(mk_date(31, 1, 1999), mk_date(1, 2, 1999));
    queue_pair(mk_date(31, 12, 1999), mk_date(31, 12, 2000));
    queue_pair(mk_date(30, 11, 2100), mk_date(1, 3, 2100));
    queue_pair(mk_date(29, 2, 2400), mk_date(28, 2, 2100));
    queue_pair(mk_date(15, 6, 5000), mk_date(14, 6, 5000));
    queue_pair(mk_date(15, 7, 5000), mk_date(15, 6, 5000));
    queue_pair(mk_date(1, 1, 9999), mk_date(31, 12, 9998));
    queue_pair(mk_date(16, 8, 10922), mk_date(21, 10, 5461));
    wait_all_results();

    run_random_phase(20, 48, 1'b1);
    run_random_phase(48, 20, 1'b0);
    run_random_phase(0, 0, 1'b0);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_outcomes.size() == 0)
      $display("PASS calendar_date_unit");
    else
      $display("FAIL calendar_date_unit");
    $finish;
  end

endmodule
